// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the regex syntax checker.
// No dependencies; taken in by `include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, not while reset is high.
`define RSC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("regex syntax checker assertion failed");

// Condition that must never be seen outside reset.
`define RSC_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("regex syntax checker forbidden condition seen");

`endif

// ===== design/rsc_pkg.sv =====
// Types and constants of the regex syntax checker.
// No dependencies; used by every module of the block.
`default_nettype none

package rsc_pkg;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_EMPTY     = 4'd1,
    ST_QUANT     = 4'd2,
    ST_EMPTY_BR  = 4'd3,
    ST_CARET     = 4'd4,
    ST_DOLLAR    = 4'd5,
    ST_BACKSLASH = 4'd6,
    ST_UNCLOSED  = 4'd7,
    ST_END_EMPTY = 4'd8
  } status_t;

  typedef struct packed {
    logic    escape_pending;
    logic    inside_class;
    logic    operand_seen;
    logic    quantifier_just_seen;
    logic    branch_has_content;
    logic    dollar_check;
    status_t error_status;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    escape_pending:       1'b0,
    inside_class:         1'b0,
    operand_seen:         1'b0,
    quantifier_just_seen: 1'b0,
    branch_has_content:   1'b0,
    dollar_check:         1'b0,
    error_status:         ST_OK
  };

  // Control between the pattern stage and the result register.
  typedef struct packed {
    logic load;
  } out_ctl_t;

  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_PIPE      = 8'h7C;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

endpackage

`default_nettype wire

// ===== design/rsc_step.sv =====
// Next-state and status logic for one pattern byte of the syntax checker.
// Purely combinational; depends on rsc_pkg.
`default_nettype none

module rsc_step (
  input  rsc_pkg::flags_t  cur,
  input  logic [7:0]       symbol,
  input  logic             has_symbol,
  input  logic             last,
  output rsc_pkg::flags_t  nxt,
  output rsc_pkg::status_t status
);
  import rsc_pkg::*;

  logic   quant;
  flags_t upd;

  assign quant = (symbol == CH_STAR) || (symbol == CH_PLUS) || (symbol == CH_QUESTION);

  always_comb begin
    upd = cur;
    if (cur.error_status == ST_OK) begin
      if (!has_symbol) begin
        upd.error_status = ST_EMPTY;
      end else begin
        upd.dollar_check = 1'b0;
        // The byte after a dollar must be a raw bar, before any other handling.
        priority if (cur.dollar_check && (symbol != CH_PIPE)) begin
          upd.error_status = ST_DOLLAR;
        end else if (cur.escape_pending) begin
          upd.escape_pending       = 1'b0;
          upd.operand_seen         = 1'b1;
          upd.branch_has_content   = 1'b1;
          upd.quantifier_just_seen = 1'b0;
        end else if (symbol == CH_BACKSLASH) begin
          upd.escape_pending = 1'b1;
        end else if ((symbol == CH_LBRACKET) && !cur.inside_class) begin
          upd.inside_class         = 1'b1;
          upd.operand_seen         = 1'b1;
          upd.branch_has_content   = 1'b1;
          upd.quantifier_just_seen = 1'b0;
        end else if ((symbol == CH_RBRACKET) && cur.inside_class) begin
          upd.inside_class = 1'b0;
        end else if (cur.inside_class) begin
          upd.inside_class = 1'b1;
        end else if (quant) begin
          if (!cur.operand_seen || cur.quantifier_just_seen) begin
            upd.error_status = ST_QUANT;
          end else begin
            upd.quantifier_just_seen = 1'b1;
          end
        end else if (symbol == CH_PIPE) begin
          if (!cur.branch_has_content) begin
            upd.error_status = ST_EMPTY_BR;
          end else begin
            upd.operand_seen         = 1'b0;
            upd.branch_has_content   = 1'b0;
            upd.quantifier_just_seen = 1'b0;
          end
        end else if (symbol == CH_CARET) begin
          if (cur.branch_has_content) begin
            upd.error_status = ST_CARET;
          end else begin
            upd.quantifier_just_seen = 1'b0;
          end
        end else if (symbol == CH_DOLLAR) begin
          upd.dollar_check         = 1'b1;
          upd.quantifier_just_seen = 1'b0;
        end else begin
          upd.operand_seen         = 1'b1;
          upd.branch_has_content   = 1'b1;
          upd.quantifier_just_seen = 1'b0;
        end
      end
    end

    status = upd.error_status;
    if (upd.error_status == ST_OK) begin
      priority if (upd.escape_pending) begin
        status = ST_BACKSLASH;
      end else if (upd.inside_class) begin
        status = ST_UNCLOSED;
      end else if (!upd.branch_has_content) begin
        status = ST_END_EMPTY;
      end else begin
        status = ST_OK;
      end
    end

    // A finished pattern leaves the checker ready for the next one.
    nxt = last ? FLAGS_RESET : upd;
  end

endmodule

`default_nettype wire

// ===== design/rsc_out_reg.sv =====
// Result register of the syntax checker: holds one status word until taken.
// Depends on rsc_pkg.
`default_nettype none

module rsc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  rsc_pkg::out_ctl_t ctl_in,
  input  rsc_pkg::status_t  status_in,
  input  logic              status_stall,
  output logic              status_valid,
  output rsc_pkg::status_t  status_q,
  output logic              busy
);
  import rsc_pkg::*;

  logic status_valid_next;

  // The register is busy when it holds a word the consumer does not take now.
  assign busy = status_valid && status_stall;

  always_comb begin
    priority if (ctl_in.load) begin
      status_valid_next = 1'b1;
    end else if (!status_stall) begin
      status_valid_next = 1'b0;
    end else begin
      status_valid_next = status_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else begin
      status_valid <= status_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.load) begin
      status_q <= status_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/regex_syntax_checker.sv =====
// Top level of the regex syntax checker: input register, flag state, result.
// Depends on rsc_pkg, rsc_step, rsc_out_reg and assert_macros.svh.
//
//   channel  | handshake                  | words
//   ---------+----------------------------+-----------------------------------
//   pattern  | sym_valid / sym_stall      | symbol[7:0], has_symbol, last
//   result   | status_valid / status_stall| status[3:0], one per last word
//
// One pattern word is taken every cycle while sym_stall is low; it is
// registered, then updates the flags, and on a last word the status is
// loaded into the result register with the flag update. The flag update
// is the only loop. Reset clears the flags and the input and result valid bits.
// A stalled result blocks only a following last word; other words flow on.
`default_nettype none

module regex_syntax_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       sym_valid,
  output logic       sym_stall,
  input  logic [7:0] symbol,
  input  logic       has_symbol,
  input  logic       last,
  output logic       status_valid,
  input  logic       status_stall,
  output logic [3:0] status
);
  import rsc_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_symbol;
  logic       s1_has_symbol;
  logic       s1_last;
  logic       s1_adv;
  logic       out_busy;
  flags_t     flags;
  flags_t     flags_next;
  status_t    step_status;
  status_t    status_q;
  out_ctl_t   out_ctl;

  // A registered word moves on unless it carries a result the register
  // cannot take.
  assign s1_adv    = s1_valid && !(s1_last && out_busy);
  assign sym_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sym_stall) begin
      s1_valid <= sym_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sym_stall && sym_valid) begin
      s1_symbol     <= symbol;
      s1_has_symbol <= has_symbol;
      s1_last       <= last;
    end
  end

  rsc_step u_step (
    .cur        (flags),
    .symbol     (s1_symbol),
    .has_symbol (s1_has_symbol),
    .last       (s1_last),
    .nxt        (flags_next),
    .status     (step_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= FLAGS_RESET;
    end else if (s1_adv) begin
      flags <= flags_next;
    end
  end

  assign out_ctl.load = s1_adv && s1_last;

  rsc_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .ctl_in       (out_ctl),
    .status_in    (step_status),
    .status_stall (status_stall),
    .status_valid (status_valid),
    .status_q     (status_q),
    .busy         (out_busy)
  );

  assign status = status_q;

`include "assert_macros.svh"

  `RSC_ASSERT(a_load_sets_valid, clk, rst, out_ctl.load |=> status_valid)
  `RSC_ASSERT(a_last_clears_flags, clk, rst, out_ctl.load |=> (flags == FLAGS_RESET))
  `RSC_ASSERT(a_error_latched, clk, rst,
    ((flags.error_status != ST_OK) && !out_ctl.load) |=>
      (flags.error_status == $past(flags.error_status)))
  `RSC_NEVER(a_stall_cause, clk, rst,
    sym_stall && !(s1_valid && s1_last && status_valid && status_stall))

endmodule

`default_nettype wire

// ===== test/regex_syntax_checker_test.sv =====
// Testbench for the regex syntax checker: directed and random patterns, checked
// against a predictor kept in the testbench. Depends on rsc_pkg and the top level.
module regex_syntax_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rsc_pkg::*;

  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         EMPTY_MARK   = 256;
  localparam logic [7:0] CH_LETTER_A  = 8'h61;

  logic       clk;
  logic       rst;
  logic       sym_valid;
  logic       sym_stall;
  logic [7:0] symbol;
  logic       has_symbol;
  logic       last;
  logic       status_valid;
  logic       status_stall;
  logic [3:0] status;

  regex_syntax_checker dut (
    .clk          (clk),
    .rst          (rst),
    .sym_valid    (sym_valid),
    .sym_stall    (sym_stall),
    .symbol       (symbol),
    .has_symbol   (has_symbol),
    .last         (last),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status       (status)
  );

  // Predicted syntax state of the pattern in flight.
  logic    esc_pend;
  logic    in_class;
  logic    have_operand;
  logic    after_quant;
  logic    branch_filled;
  logic    dollar_pend;
  status_t latched;

  status_t expected_status[$];
  int      pattern_words[$];
  int      fail_count;
  int      live_words;
  int      cycle_count;
  bit      idle_on;
  bit      hold_pending;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("regex_syntax_checker: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_pattern();
    esc_pend      = 1'b0;
    in_class      = 1'b0;
    have_operand  = 1'b0;
    after_quant   = 1'b0;
    branch_filled = 1'b0;
    dollar_pend   = 1'b0;
    latched       = ST_OK;
  endfunction

  function automatic void note_operand();
    have_operand  = 1'b1;
    branch_filled = 1'b1;
    after_quant   = 1'b0;
  endfunction

  task automatic absorb_byte(input logic [7:0] c);
    // The byte after a dollar is compared raw, ahead of escape and class handling.
    if (dollar_pend) begin
      dollar_pend = 1'b0;
      if (c != CH_PIPE) begin
        latched = ST_DOLLAR;
        return;
      end
    end
    if (esc_pend) begin
      esc_pend = 1'b0;
      note_operand();
      return;
    end
    if (c == CH_BACKSLASH) begin
      esc_pend = 1'b1;
      return;
    end
    if (c == CH_LBRACKET && !in_class) begin
      in_class = 1'b1;
      note_operand();
      return;
    end
    if (c == CH_RBRACKET && in_class) begin
      in_class = 1'b0;
      return;
    end
    if (in_class) return;
    if (c == CH_STAR || c == CH_PLUS || c == CH_QUESTION) begin
      if (!have_operand || after_quant) latched = ST_QUANT;
      else after_quant = 1'b1;
      return;
    end
    if (c == CH_PIPE) begin
      if (!branch_filled) begin
        latched = ST_EMPTY_BR;
      end else begin
        have_operand  = 1'b0;
        branch_filled = 1'b0;
        after_quant   = 1'b0;
      end
    end else if (c == CH_CARET) begin
      if (branch_filled) latched = ST_CARET;
      else after_quant = 1'b0;
    end else if (c == CH_DOLLAR) begin
      dollar_pend = 1'b1;
      after_quant = 1'b0;
    end else begin
      note_operand();
    end
  endtask

  task automatic predict_word(input logic [7:0] b, input logic h, input logic l);
    status_t verdict;
    if (latched == ST_OK) begin
      live_words++;
      if (h) absorb_byte(b);
      else latched = ST_EMPTY;
    end
    if (l) begin
      verdict = latched;
      if (verdict == ST_OK) begin
        if (esc_pend) verdict = ST_BACKSLASH;
        else if (in_class) verdict = ST_UNCLOSED;
        else if (!branch_filled) verdict = ST_END_EMPTY;
      end
      expected_status.push_back(verdict);
      clear_pattern();
    end
  endtask

  // Offers one word after an optional gap and returns at the edge that takes it.
  task automatic send_word(input logic [7:0] b, input logic h, input logic l);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      sym_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sym_valid  <= 1'b1;
    symbol     <= b;
    has_symbol <= h;
    last       <= l;
    @(posedge clk);
    while (sym_stall) @(posedge clk);
    predict_word(b, h, l);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, i == s.len() - 1);
  endtask

  task automatic send_pattern_words();
    int n;
    n = pattern_words.size();
    for (int i = 0; i < n; i++) begin
      send_word(pattern_words[i][7:0], pattern_words[i] != EMPTY_MARK, i == n - 1);
    end
  endtask

  function automatic bit is_special(input logic [7:0] v);
    return v == CH_STAR || v == CH_PLUS || v == CH_QUESTION || v == CH_PIPE ||
           v == CH_CARET || v == CH_DOLLAR || v == CH_LBRACKET ||
           v == CH_RBRACKET || v == CH_BACKSLASH;
  endfunction

  function automatic logic [7:0] pick_tricky();
    case ($urandom_range(0, 10))
      0:       return CH_STAR;
      1:       return CH_PLUS;
      2:       return CH_QUESTION;
      3:       return CH_PIPE;
      4:       return CH_CARET;
      5:       return CH_DOLLAR;
      6:       return CH_LBRACKET;
      7:       return CH_RBRACKET;
      8:       return CH_BACKSLASH;
      9:       return CH_LETTER_A;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Builds a mostly well-formed pattern and damages some of them; some are short runs of tricky bytes instead.
  task automatic make_pattern();
    int          nbr;
    int          natoms;
    int          pos;
    logic [7:0]  v;
    pattern_words.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) pattern_words.push_back(pick_tricky());
      return;
    end
    nbr = $urandom_range(1, 3);
    for (int b = 0; b < nbr; b++) begin
      if (b > 0) pattern_words.push_back(CH_PIPE);
      if ($urandom_range(0, 5) == 0) pattern_words.push_back(CH_CARET);
      natoms = $urandom_range(1, 4);
      for (int a = 0; a < natoms; a++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            do v = 8'($urandom_range(0, 255)); while (is_special(v));
            pattern_words.push_back(v);
          end
          5, 6: begin
            pattern_words.push_back(CH_BACKSLASH);
            pattern_words.push_back($urandom_range(0, 255));
          end
          default: begin
            pattern_words.push_back(CH_LBRACKET);
            repeat ($urandom_range(0, 3)) begin
              do v = 8'($urandom_range(0, 255));
              while (v == CH_RBRACKET || v == CH_BACKSLASH);
              pattern_words.push_back(v);
            end
            pattern_words.push_back(CH_RBRACKET);
          end
        endcase
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 2))
            0:       pattern_words.push_back(CH_STAR);
            1:       pattern_words.push_back(CH_PLUS);
            default: pattern_words.push_back(CH_QUESTION);
          endcase
        end
      end
      if ($urandom_range(0, 5) == 0) pattern_words.push_back(CH_DOLLAR);
    end
    if ($urandom_range(0, 9) < 3) begin
      pos = $urandom_range(0, pattern_words.size() - 1);
      case ($urandom_range(0, 4))
        0: pattern_words[pos] = pick_tricky();
        1: pattern_words.insert(pos, pick_tricky());
        2: pattern_words = pattern_words[0:pos];
        3: pattern_words.insert(pos, EMPTY_MARK);
        default: pattern_words.push_back($urandom_range(0, 1) ? CH_BACKSLASH : CH_LBRACKET);
      endcase
    end
  endtask

  // Receiver: random stall runs, plus a long hold when a test asks for one.
  initial begin
    int  hold_left;
    int  run_left;
    bit  stall_run;
    hold_left = 0;
    run_left = 0;
    stall_run = 1'b0;
    status_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        status_stall <= 1'b1;
      end else if (!idle_on) begin
        status_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stall_run = ($urandom_range(0, 3) == 0);
          run_left = stall_run ? 1 + pick_gap() : $urandom_range(1, 12);
        end
        run_left--;
        status_stall <= stall_run;
      end
    end
  end

  // Every status word taken is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && status_valid && !status_stall) begin
      if (expected_status.size() == 0) begin
        $error("status: no result expected, got %0d", status);
        fail_count++;
      end else if (status !== expected_status[0]) begin
        $error("status: expected %0d, got %0d", expected_status[0], status);
        fail_count++;
        void'(expected_status.pop_front());
      end else begin
        void'(expected_status.pop_front());
      end
    end
  end

  task automatic test_extremes();
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_error_cases();
    send_text("?");
    send_text("a+*");
    send_text("|");
    send_text("a^");
    send_text("$a");
    send_text("\\");
    send_text("[");
    send_text("a|");
  endtask

  task automatic test_special_cases();
    // A dollar still pending at the end is fine; the byte after one is taken raw.
    send_text("a$");
    send_text("$\\");
    // An empty mark after bytes still reports an empty pattern.
    send_word(CH_LETTER_A, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_patterns(input int target);
    live_words = 0;
    while (live_words < target) begin
      make_pattern();
      send_pattern_words();
    end
  endtask

  task automatic test_backpressure();
    hold_pending = 1'b1;
    repeat (40) send_word($urandom_range(0, 1) ? CH_LETTER_A : CH_PIPE, 1'b1, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    sym_valid = 1'b0;
    symbol = 8'h00;
    has_symbol = 1'b0;
    last = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    hold_pending = 1'b0;
    clear_pattern();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_error_cases();
    test_special_cases();
    test_random_patterns(1300);
    idle_on = 1'b0;
    test_backpressure();
    test_random_patterns(300);
    idle_on = 1'b1;

    sym_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("regex_syntax_checker: match");
    end else begin
      $display("regex_syntax_checker: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/rsc_pkg.sv
design/rsc_step.sv
design/rsc_out_reg.sv
design/regex_syntax_checker.sv
test/regex_syntax_checker_test.sv
